>>> hw/rtl/mpfde_pkg.sv
// ============================================================================
// mpfde_pkg
// Shared types and constants for the page frame store drawing engine.
// ============================================================================
package mpfde_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 32;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int XW            = $clog2(SCREEN_WIDTH);
    localparam int YW            = $clog2(SCREEN_HEIGHT);
    localparam int QDEPTH        = 2;

    localparam logic [2:0] REQ_PIXEL = 3'd0;
    localparam logic [2:0] REQ_HLINE = 3'd1;
    localparam logic [2:0] REQ_VLINE = 3'd2;
    localparam logic [2:0] REQ_RECT  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;
    localparam logic [2:0] REQ_READ  = 3'd5;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_INV   = 3'd1;
    localparam logic [2:0] MODE_OR    = 3'd2;
    localparam logic [2:0] MODE_IAND  = 3'd3;
    localparam logic [2:0] MODE_XOR   = 3'd4;

    typedef enum logic [2:0] {
        OP_DRAW  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_READ  = 3'd2,
        OP_NONE  = 3'd3
    } t_op;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [11:0] first_x;
        logic signed [11:0] first_y;
        logic signed [11:0] second_x;
        logic signed [11:0] second_y;
        logic              pixel_value;
        logic [2:0]        write_mode;
        logic [8:0]        read_index;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       fully_clipped;
    } t_rsp;

    // Classified, clipped job handed from front to back.
    typedef struct packed {
        t_op             op;
        logic            vert;
        logic            clipped;
        logic [XW-1:0]   x_lo;
        logic [XW-1:0]   x_hi;
        logic [YW-1:0]   y_lo;
        logic [YW-1:0]   y_hi;
        logic            pix;
        logic [2:0]      mode;
        logic [8:0]      ridx;
    } t_job;

    function automatic logic [7:0] apply_mode(logic [7:0] b, logic [7:0] m,
                                              logic p, logic [2:0] mode);
        logic [7:0] r;
        r = b;
        case (mode)
            MODE_WRITE: r = p ? (b | m) : (b & ~m);
            MODE_INV:   r = p ? (b & ~m) : (b | m);
            MODE_OR:    r = p ? (b | m) : b;
            MODE_IAND:  r = p ? b : (b & ~m);
            MODE_XOR:   r = p ? (b ^ m) : b;
            default:    r = b;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/mono_page_framebuffer_draw_engine_core.sv
// ============================================================================
// mono_page_framebuffer_draw_engine_core
// Drawing engine over a page-organised monochrome frame store.
// ============================================================================
// Channel   Direction  Handshake         Payload
// command   in         i_start, o_busy   i_req (t_req)
// result    out        o_done strobe     o_rsp (t_rsp)
//
// A draw does one byte access, a read state then a write state, per pixel of a
// rectangle or horizontal line and per page of a vertical line, after passing the
// front-end register and the queue. Clear and the reset fill sweep the store's
// 512 bytes one byte a cycle. One command may queue behind the fill after reset.
// A command is taken when i_start is high and o_busy is low.
// The result strobe lasts one cycle; the receiver cannot stall it.
module mono_page_framebuffer_draw_engine_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mpfde_pkg::t_req i_req,
    output logic            o_busy,
    output logic            o_done,
    output mpfde_pkg::t_rsp o_rsp
);
    logic            push, pop, empty, full, fbusy, idle;
    mpfde_pkg::t_job fjob, qjob;

    mpfde_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .i_full(full), .o_push(push), .o_job(fjob), .o_busy(fbusy)
    );

    mpfde_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob),
        .i_pop(pop), .o_empty(empty), .o_full(full), .o_job(qjob)
    );

    mpfde_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(qjob),
        .o_pop(pop), .o_idle(idle), .o_valid(o_done), .o_rsp(o_rsp)
    );

    assign o_busy = fbusy;

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !(full && !pop)) else $error("push into full queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> idle) else $error("pop while back end busy");
endmodule

>>> hw/rtl/mpfde_front.sv
// ============================================================================
// mpfde_front
// Classifies and clips commands into jobs for the back end.
// ============================================================================
module mpfde_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mpfde_pkg::t_req      i_req,
    input  logic                 i_full,
    output logic                 o_push,
    output mpfde_pkg::t_job      o_job,
    output logic                 o_busy
);
    logic signed [12:0] xa, xb, ya, yb, xlo, xhi, ylo, yhi;
    logic               x_off, y_off;
    mpfde_pkg::t_job    n_job, r_job;
    logic               r_push;

    always_comb begin
        xa = {i_req.first_x[11], i_req.first_x};
        ya = {i_req.first_y[11], i_req.first_y};
        case (i_req.req_type)
            mpfde_pkg::REQ_PIXEL: begin
                xb = xa;
                yb = ya;
            end
            mpfde_pkg::REQ_HLINE: begin
                xb = {i_req.second_x[11], i_req.second_x};
                yb = ya;
            end
            mpfde_pkg::REQ_VLINE: begin
                xb = xa;
                yb = {i_req.second_y[11], i_req.second_y};
            end
            default: begin
                xb = {i_req.second_x[11], i_req.second_x};
                yb = {i_req.second_y[11], i_req.second_y};
            end
        endcase
        xlo = (xa < xb) ? xa : xb;
        xhi = (xa < xb) ? xb : xa;
        ylo = (ya < yb) ? ya : yb;
        yhi = (ya < yb) ? yb : ya;
        x_off = (xhi < 0) || (xlo >= 13'(mpfde_pkg::SCREEN_WIDTH));
        y_off = (yhi < 0) || (ylo >= 13'(mpfde_pkg::SCREEN_HEIGHT));
        if (xlo < 0) xlo = '0;
        if (xhi >= 13'(mpfde_pkg::SCREEN_WIDTH)) xhi = 13'(mpfde_pkg::SCREEN_WIDTH - 1);
        if (ylo < 0) ylo = '0;
        if (yhi >= 13'(mpfde_pkg::SCREEN_HEIGHT)) yhi = 13'(mpfde_pkg::SCREEN_HEIGHT - 1);

        n_job.vert    = (i_req.req_type == mpfde_pkg::REQ_VLINE);
        n_job.clipped = x_off || y_off;
        n_job.x_lo    = xlo[mpfde_pkg::XW-1:0];
        n_job.x_hi    = xhi[mpfde_pkg::XW-1:0];
        n_job.y_lo    = ylo[mpfde_pkg::YW-1:0];
        n_job.y_hi    = yhi[mpfde_pkg::YW-1:0];
        n_job.pix     = (i_req.req_type == mpfde_pkg::REQ_PIXEL) ? i_req.pixel_value : 1'b1;
        n_job.mode    = i_req.write_mode;
        n_job.ridx    = i_req.read_index;
        case (i_req.req_type)
            mpfde_pkg::REQ_PIXEL, mpfde_pkg::REQ_HLINE,
            mpfde_pkg::REQ_VLINE, mpfde_pkg::REQ_RECT: n_job.op = mpfde_pkg::OP_DRAW;
            mpfde_pkg::REQ_CLEAR: n_job.op = mpfde_pkg::OP_CLEAR;
            mpfde_pkg::REQ_READ:  n_job.op = mpfde_pkg::OP_READ;
            default:              n_job.op = mpfde_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
        end else begin
            r_push <= i_start && !o_busy;
        end
        if (i_start && !o_busy) begin
            r_job <= n_job;
        end
    end

    assign o_busy = i_full || r_push;
    assign o_push = r_push;
    assign o_job  = r_job;
endmodule

>>> hw/rtl/mpfde_queue.sv
// ============================================================================
// mpfde_queue
// Short job queue between the front and back ends.
// ============================================================================
module mpfde_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpfde_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output mpfde_pkg::t_job o_job
);
    localparam int PW = $clog2(mpfde_pkg::QDEPTH);
    mpfde_pkg::t_job r_mem [mpfde_pkg::QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt >= (PW+1)'(mpfde_pkg::QDEPTH - 1));
    assign o_job   = r_mem[r_rp];
endmodule

>>> hw/rtl/mpfde_back.sv
// ============================================================================
// mpfde_back
// Carries out jobs on the frame store: draws as byte read-modify-writes, clears and reads.
// ============================================================================
module mpfde_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mpfde_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_idle,
    output logic            o_valid,
    output mpfde_pkg::t_rsp o_rsp
);
    localparam int AW = mpfde_pkg::ADDR_W;
    localparam int PGW = (mpfde_pkg::PAGE_COUNT > 1) ? $clog2(mpfde_pkg::PAGE_COUNT) : 1;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD    = 6'b000100,
        ST_WR    = 6'b001000,
        ST_CLR   = 6'b010000,
        ST_RDATA = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [7:0]      r_mem [mpfde_pkg::STORE_BYTES];
    logic [7:0]      r_q;
    mpfde_pkg::t_job r_job;
    logic [mpfde_pkg::XW-1:0] r_x;
    logic [mpfde_pkg::YW-1:0] r_y;
    logic [AW-1:0]   r_clr;
    logic            r_valid, n_valid;
    mpfde_pkg::t_rsp r_rsp;

    logic [AW-1:0]   addr;
    logic [7:0]      mask, mlo, mhi;
    logic [PGW-1:0]  page, pg_lo, pg_hi;
    logic            last_x, last_y, last_step;
    logic            rd_oob;

    function automatic logic [mpfde_pkg::YW-1:0] YW_ADD(logic [mpfde_pkg::YW-1:0] y);
        return y + mpfde_pkg::YW'(8);
    endfunction

    always_comb begin
        page  = PGW'(r_y >> 3);
        pg_lo = PGW'(r_job.y_lo >> 3);
        pg_hi = PGW'(r_job.y_hi >> 3);
        addr  = AW'(r_x) + AW'(32'(page) * mpfde_pkg::SCREEN_WIDTH);
        mlo   = 8'hFF << r_job.y_lo[2:0];
        mhi   = 8'hFF >> (3'd7 - r_job.y_hi[2:0]);
        if (r_job.vert) begin
            mask = 8'hFF;
            if (page == pg_lo) mask = mask & mlo;
            if (page == pg_hi) mask = mask & mhi;
        end else begin
            mask = 8'h01 << r_y[2:0];
        end
        last_x = (r_x == r_job.x_hi);
        last_y = r_job.vert ? (page == pg_hi) : (r_y == r_job.y_hi);
        last_step = last_x && last_y;
        rd_oob = (32'(r_job.ridx) >= mpfde_pkg::STORE_BYTES);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:  if (r_clr == AW'(mpfde_pkg::STORE_BYTES - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_job.op)
                        mpfde_pkg::OP_DRAW:  n_state = i_job.clipped ? ST_IDLE : ST_RD;
                        mpfde_pkg::OP_CLEAR: n_state = ST_CLR;
                        mpfde_pkg::OP_READ:  n_state = ST_RDATA;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD:    n_state = ST_WR;
            ST_WR:    n_state = last_step ? ST_IDLE : ST_RD;
            ST_CLR:   if (r_clr == AW'(mpfde_pkg::STORE_BYTES - 1)) n_state = ST_IDLE;
            ST_RDATA: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: n_valid = !i_empty && (i_job.op != mpfde_pkg::OP_READ) &&
                               !(i_job.op == mpfde_pkg::OP_DRAW && !i_job.clipped);
            ST_WR:    n_valid = last_step;
            ST_RDATA: n_valid = 1'b1;
            default:  n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == ST_INIT || r_state == ST_CLR) r_clr <= r_clr + 1'b1;
            else r_clr <= '0;
        end
        case (r_state)
            ST_INIT, ST_CLR: r_mem[r_clr] <= 8'h00;
            ST_RD:  r_q <= r_mem[addr];
            ST_WR:  r_mem[addr] <= mpfde_pkg::apply_mode(r_q, mask, r_job.pix, r_job.mode);
            ST_RDATA: r_q <= r_mem[r_job.ridx[AW-1:0]];
            default: ;
        endcase
        if (r_state == ST_IDLE && !i_empty) begin
            r_job <= i_job;
            r_x   <= i_job.x_lo;
            r_y   <= i_job.y_lo;
            r_rsp.read_data     <= 8'h00;
            r_rsp.fully_clipped <= (i_job.op == mpfde_pkg::OP_DRAW) && i_job.clipped;
        end
        if (r_state == ST_WR && !last_step) begin
            if (last_x) begin
                r_x <= r_job.x_lo;
                r_y <= r_job.vert ? YW_ADD(r_y) : r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_idle  = (r_state == ST_IDLE);
    assign o_valid = r_valid;
    always_comb begin
        o_rsp = r_rsp;
        if (r_job.op == mpfde_pkg::OP_READ) o_rsp.read_data = rd_oob ? 8'h00 : r_q;
    end
endmodule

>>> tb/tb_mono_page_framebuffer_draw_engine_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_mono_page_framebuffer_draw_engine_core
// Self-checking bench for the page frame store drawing engine. Commands are
// driven from a queue through the start/busy handshake, a behavioral frame
// store predicts each response, and the monitor compares every done strobe.
// ============================================================================
module tb_mono_page_framebuffer_draw_engine_core;

    localparam int W = mpfde_pkg::SCREEN_WIDTH;
    localparam int H = mpfde_pkg::SCREEN_HEIGHT;
    localparam int NBYTES = mpfde_pkg::STORE_BYTES;
    localparam longint CYCLE_LIMIT = 20000000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    mpfde_pkg::t_req i_req;
    logic o_busy;
    logic o_done;
    mpfde_pkg::t_rsp o_rsp;

    mono_page_framebuffer_draw_engine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp)
    );

    logic [7:0] model_store [NBYTES];
    mpfde_pkg::t_req pending_cmds[$];
    mpfde_pkg::t_rsp expected_rsps[$];
    int idle_pct;
    int errors;
    int n_cmds;
    int n_rsps;
    longint cycle_count;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void store_write(int idx, logic [7:0] m, logic p, logic [2:0] mode);
        logic [7:0] b;
        if (idx < 0 || idx >= NBYTES) return;
        b = model_store[idx];
        case (mode)
            mpfde_pkg::MODE_WRITE: b = p ? (b | m) : (b & ~m);
            mpfde_pkg::MODE_INV: b = p ? (b & ~m) : (b | m);
            mpfde_pkg::MODE_OR: if (p) b = b | m;
            mpfde_pkg::MODE_IAND: if (!p) b = b & ~m;
            mpfde_pkg::MODE_XOR: if (p) b = b ^ m;
            default: b = b;
        endcase
        model_store[idx] = b;
    endfunction

    function automatic bit draw_row(int xa, int xb, int y, logic [2:0] mode);
        int lo;
        int hi;
        lo = xa < xb ? xa : xb;
        hi = xa < xb ? xb : xa;
        if (y < 0 || y >= H || hi < 0 || lo >= W) return 1'b0;
        if (lo < 0) lo = 0;
        if (hi >= W) hi = W - 1;
        for (int x = lo; x <= hi; x++)
            store_write(x + (y >> 3) * W, 8'(1 << (y & 7)), 1'b1, mode);
        return 1'b1;
    endfunction

    function automatic bit draw_column(int x, int ya, int yb, logic [2:0] mode);
        int lo;
        int hi;
        logic [7:0] m;
        lo = ya < yb ? ya : yb;
        hi = ya < yb ? yb : ya;
        if (x < 0 || x >= W || hi < 0 || lo >= H) return 1'b0;
        if (lo < 0) lo = 0;
        if (hi >= H) hi = H - 1;
        for (int pg = lo >> 3; pg <= hi >> 3; pg++) begin
            m = 8'hFF;
            if (pg == lo >> 3) m = m & (8'hFF << (lo & 7));
            if (pg == hi >> 3) m = m & (8'hFF >> (7 - (hi & 7)));
            store_write(pg * W + x, m, 1'b1, mode);
        end
        return 1'b1;
    endfunction

    function automatic mpfde_pkg::t_rsp predict_response(mpfde_pkg::t_req r);
        mpfde_pkg::t_rsp rsp;
        int x1;
        int y1;
        int x2;
        int y2;
        int lo;
        int hi;
        bit hit;
        x1 = r.first_x;
        y1 = r.first_y;
        x2 = r.second_x;
        y2 = r.second_y;
        rsp = '0;
        hit = 1'b0;
        case (r.req_type)
            mpfde_pkg::REQ_PIXEL: begin
                if (x1 >= 0 && x1 < W && y1 >= 0 && y1 < H) begin
                    store_write(x1 + (y1 >> 3) * W, 8'(1 << (y1 & 7)), r.pixel_value,
                                r.write_mode);
                    hit = 1'b1;
                end
                rsp.fully_clipped = !hit;
            end
            mpfde_pkg::REQ_HLINE: rsp.fully_clipped = !draw_row(x1, x2, y1, r.write_mode);
            mpfde_pkg::REQ_VLINE: rsp.fully_clipped = !draw_column(x1, y1, y2, r.write_mode);
            mpfde_pkg::REQ_RECT: begin
                lo = y1 < y2 ? y1 : y2;
                hi = y1 < y2 ? y2 : y1;
                if (lo < 0) lo = 0;
                if (hi >= H) hi = H - 1;
                for (int y = lo; y <= hi; y++)
                    if (draw_row(x1, x2, y, r.write_mode)) hit = 1'b1;
                rsp.fully_clipped = !hit;
            end
            mpfde_pkg::REQ_CLEAR: foreach (model_store[i]) model_store[i] = '0;
            mpfde_pkg::REQ_READ:
                if (r.read_index < NBYTES) rsp.read_data = model_store[r.read_index];
            default: rsp = '0;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                expected_rsps.push_back(predict_response(i_req));
                n_cmds++;
            end
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_req <= pending_cmds.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
                i_req <= mpfde_pkg::t_req'($urandom());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_done) begin
            n_rsps++;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                errors++;
            end else begin
                mpfde_pkg::t_rsp e;
                e = expected_rsps.pop_front();
                if (e.read_data !== o_rsp.read_data)
                    $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                             o_rsp.read_data);
                if (e.fully_clipped !== o_rsp.fully_clipped)
                    $display("%0t: fully_clipped expected %b actual %b", $time,
                             e.fully_clipped, o_rsp.fully_clipped);
                if (e !== o_rsp) errors++;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [11:0] pick_coord(int span);
        case ($urandom_range(9))
            0: return 12'($urandom());
            1: return -12'sd1 - 12'($urandom_range(20));
            2: return 12'(span + $urandom_range(20));
            default: return 12'($urandom_range(span - 1));
        endcase
    endfunction

    function automatic mpfde_pkg::t_req random_cmd();
        mpfde_pkg::t_req r;
        int k;
        r = mpfde_pkg::t_req'({$urandom(), $urandom()});
        k = $urandom_range(99);
        if (k < 5) r.req_type = 3'($urandom_range(6, 7));
        else if (k < 8) r.req_type = mpfde_pkg::REQ_CLEAR;
        else if (k < 35) r.req_type = mpfde_pkg::REQ_READ;
        else if (k < 55) r.req_type = mpfde_pkg::REQ_PIXEL;
        else if (k < 70) r.req_type = mpfde_pkg::REQ_HLINE;
        else if (k < 85) r.req_type = mpfde_pkg::REQ_VLINE;
        else r.req_type = mpfde_pkg::REQ_RECT;
        if ($urandom_range(9) != 0) begin
            r.first_x = pick_coord(W);
            r.second_x = pick_coord(W);
            r.first_y = pick_coord(H);
            r.second_y = pick_coord(H);
            r.write_mode = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(4));
            r.read_index = ($urandom_range(9) == 0) ? 9'($urandom())
                                                    : 9'($urandom_range(NBYTES - 1));
        end
        if (r.req_type == mpfde_pkg::REQ_RECT && $urandom_range(3) != 0) begin
            r.first_y = 12'($urandom_range(H - 1));
            r.second_y = r.first_y + 12'($urandom_range(3));
        end
        return r;
    endfunction

    function automatic mpfde_pkg::t_req make_cmd(logic [2:0] rt, int x1, int y1, int x2,
                                                 int y2, logic p, logic [2:0] mode,
                                                 int ridx);
        mpfde_pkg::t_req r;
        r.req_type = rt;
        r.first_x = 12'(x1);
        r.first_y = 12'(y1);
        r.second_x = 12'(x2);
        r.second_y = 12'(y2);
        r.pixel_value = p;
        r.write_mode = mode;
        r.read_index = 9'(ridx);
        return r;
    endfunction

    task automatic run_phase(int pct, int count);
        idle_pct = pct;
        repeat (count) pending_cmds.push_back(random_cmd());
        wait (pending_cmds.size() == 0 && !i_start);
        wait (expected_rsps.size() == 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        idle_pct = 0;
        errors = 0;
        n_cmds = 0;
        n_rsps = 0;
        cycle_count = 0;
        foreach (model_store[i]) model_store[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_READ, 0, 0, 0, 0, 0,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_PIXEL, 0, 0, 0, 0, 1,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_PIXEL, W - 1, H - 1, 0, 0, 1,
                                        mpfde_pkg::MODE_OR, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_PIXEL, -2048, 2047, 0, 0, 1,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_PIXEL, 5, 3, 0, 0, 0,
                                        mpfde_pkg::MODE_INV, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_HLINE, 2047, 9, -2048, 0, 1,
                                        mpfde_pkg::MODE_XOR, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_HLINE, W, 2, W + 50, 0, 1,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_VLINE, 7, 29, 3, 0, 1,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_VLINE, 9, -2048, 0, 2047, 1,
                                        mpfde_pkg::MODE_INV, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_VLINE, 9, -5, 0, -1, 1,
                                        mpfde_pkg::MODE_OR, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_RECT, 20, 30, 10, 5, 1,
                                        mpfde_pkg::MODE_XOR, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_RECT, -3, -3, 3, 3, 1,
                                        mpfde_pkg::MODE_IAND, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_RECT, -9, 40, -1, 50, 1,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_HLINE, 0, 4, 30, 0, 1, 3'd6, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_READ, 0, 0, 0, 0, 0,
                                        mpfde_pkg::MODE_WRITE, 7));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_READ, 0, 0, 0, 0, 0,
                                        mpfde_pkg::MODE_WRITE, NBYTES - 1));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_READ, 0, 0, 0, 0, 0,
                                        mpfde_pkg::MODE_WRITE, 511));
        pending_cmds.push_back(make_cmd(3'd7, 1, 1, 1, 1, 1, mpfde_pkg::MODE_WRITE, 3));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_CLEAR, 0, 0, 0, 0, 0,
                                        mpfde_pkg::MODE_WRITE, 0));
        pending_cmds.push_back(make_cmd(mpfde_pkg::REQ_READ, 0, 0, 0, 0, 0,
                                        mpfde_pkg::MODE_WRITE, 10));
        run_phase(0, 0);

        run_phase(0, 300);
        run_phase(75, 300);
        run_phase(0, 300);
        run_phase(37, 300);
        repeat (100) @(posedge i_clk);

        $display("Drove %0d command transactions over pixel, line, rectangle, clear, read",
                 n_cmds);
        $display("and unused types under several idle ratios; %0d responses checked.",
                 n_rsps);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/mpfde_pkg.sv
hw/rtl/mpfde_front.sv
hw/rtl/mpfde_queue.sv
hw/rtl/mpfde_back.sv
hw/rtl/mono_page_framebuffer_draw_engine_core.sv
tb/tb_mono_page_framebuffer_draw_engine_core.sv
